### rtl/core/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// When pre holds, post must hold in the next cycle, reset included.
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/trxon_pkg.sv
// Types and constants for the telnet receive option negotiator.
package trxon_pkg;

   localparam logic [7:0] B_IAC    = 8'd255;
   localparam logic [7:0] B_DONT   = 8'd254;
   localparam logic [7:0] B_DO     = 8'd253;
   localparam logic [7:0] B_WONT   = 8'd252;
   localparam logic [7:0] B_WILL   = 8'd251;
   localparam logic [7:0] B_GA     = 8'd249;
   localparam logic [7:0] B_IP     = 8'd244;
   localparam logic [7:0] B_EOR    = 8'd239;
   localparam logic [7:0] B_CR     = 8'd13;
   localparam logic [7:0] B_LF     = 8'd10;
   localparam logic [7:0] B_NUL    = 8'd0;
   localparam logic [7:0] OPT_ECHO = 8'd1;
   localparam logic [7:0] OPT_SGA  = 8'd3;
   localparam logic [7:0] OPT_EOR  = 8'd25;

   typedef enum logic [3:0] {
      CLS_OTHER,
      CLS_NUL,
      CLS_LF,
      CLS_CR,
      CLS_IAC,
      CLS_IP,
      CLS_GA,
      CLS_EOR,
      CLS_WILL,
      CLS_WONT,
      CLS_DO,
      CLS_DONT,
      CLS_OPT_ECHO,
      CLS_OPT_SGA,
      CLS_OPT_EOR
   } cls_type;

   typedef enum logic [5:0] {
      PH_DATA = 6'b000001,
      PH_IAC  = 6'b000010,
      PH_WILL = 6'b000100,
      PH_WONT = 6'b001000,
      PH_DO   = 6'b010000,
      PH_DONT = 6'b100000
   } phase_type;

   typedef enum logic [2:0] {
      LN_NONE = 3'b001,
      LN_CR   = 3'b010,
      LN_LF   = 3'b100
   } line_type;

   typedef struct packed {
      cls_type    cls;
      logic [7:0] value;
   } cmd_type;

   typedef struct packed {
      logic       data_valid;
      logic [7:0] data_byte;
      logic       prompt_mark;
      logic       reply_valid;
      logic [7:0] reply_verb;
      logic [7:0] reply_option;
      logic       close_request;
   } rsp_type;

endpackage

### rtl/core/telnet_rx_option_negotiator_unit.sv
// Top level of the telnet receive option negotiator.
//
//   channel   direction  handshake           payload
//   req       in         req_push / full     req_rx_byte
//   rsp       out        rsp_pop / empty     rsp_data_valid .. rsp_close_request
//
// One byte per cycle sustained while the rsp side pops; every accepted byte gives
// exactly one result. From accept to result visible, the byte sits in the command
// queue, then the back end writes its result into the result queue, whose head
// drives the rsp ports.
// Reset clears both queues and the parser state to the data phase.
// A stalled rsp side fills the result queue, then the command queue, then
// raises full; no transaction is lost or repeated.
module telnet_rx_option_negotiator_unit #(
   parameter int CMD_DEPTH = 4,
   parameter int RSP_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_rx_byte,
   output logic       full,
   output logic       req_full,
   output logic       empty,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_data_valid,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_prompt_mark,
   output logic       rsp_reply_valid,
   output logic [7:0] rsp_reply_verb,
   output logic [7:0] rsp_reply_option,
   output logic       rsp_close_request
);

   localparam int CMD_W = $bits(trxon_pkg::cmd_type);
   localparam int RSP_W = $bits(trxon_pkg::rsp_type);

   trxon_pkg::cmd_type cmd_in, cmd_out;
   trxon_pkg::rsp_type rsp_in, rsp_out;
   logic               cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic               rsp_push, rsp_full;

   trxon_front u_front (
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .req_full    (req_full),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_in),
      .cmd_full    (cmd_full)
   );

   trxon_queue #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty)
   );

   trxon_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_out),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_in),
      .rsp_full  (rsp_full)
   );

   trxon_queue #(.WIDTH(RSP_W), .DEPTH(RSP_DEPTH)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_out),
      .empty     (rsp_empty)
   );

   assign full              = req_full;
   assign empty             = rsp_empty;
   assign rsp_data_valid    = rsp_out.data_valid;
   assign rsp_data_byte     = rsp_out.data_byte;
   assign rsp_prompt_mark   = rsp_out.prompt_mark;
   assign rsp_reply_valid   = rsp_out.reply_valid;
   assign rsp_reply_verb    = rsp_out.reply_verb;
   assign rsp_reply_option  = rsp_out.reply_option;
   assign rsp_close_request = rsp_out.close_request;

endmodule

### rtl/core/trxon_queue.sv
// Small register-based FIFO used between the front, the back and the result port.
module trxon_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/trxon_front.sv
// Front end: accepts received bytes and tags each with its byte class.
module trxon_front (
   input  logic                 req_push,
   input  logic [7:0]           req_rx_byte,
   output logic                 req_full,
   output logic                 cmd_push,
   output trxon_pkg::cmd_type   cmd_data,
   input  logic                 cmd_full
);

   trxon_pkg::cls_type cls;

   always_comb begin
      unique case (req_rx_byte)
         trxon_pkg::B_NUL:    cls = trxon_pkg::CLS_NUL;
         trxon_pkg::B_LF:     cls = trxon_pkg::CLS_LF;
         trxon_pkg::B_CR:     cls = trxon_pkg::CLS_CR;
         trxon_pkg::B_IAC:    cls = trxon_pkg::CLS_IAC;
         trxon_pkg::B_IP:     cls = trxon_pkg::CLS_IP;
         trxon_pkg::B_GA:     cls = trxon_pkg::CLS_GA;
         trxon_pkg::B_EOR:    cls = trxon_pkg::CLS_EOR;
         trxon_pkg::B_WILL:   cls = trxon_pkg::CLS_WILL;
         trxon_pkg::B_WONT:   cls = trxon_pkg::CLS_WONT;
         trxon_pkg::B_DO:     cls = trxon_pkg::CLS_DO;
         trxon_pkg::B_DONT:   cls = trxon_pkg::CLS_DONT;
         trxon_pkg::OPT_ECHO: cls = trxon_pkg::CLS_OPT_ECHO;
         trxon_pkg::OPT_SGA:  cls = trxon_pkg::CLS_OPT_SGA;
         trxon_pkg::OPT_EOR:  cls = trxon_pkg::CLS_OPT_EOR;
         default:             cls = trxon_pkg::CLS_OTHER;
      endcase
   end

   assign req_full       = cmd_full;
   assign cmd_push       = req_push;
   assign cmd_data.cls   = cls;
   assign cmd_data.value = req_rx_byte;

endmodule

### rtl/core/trxon_back.sv
// Back end: parser, line-end folding and option negotiation state.
module trxon_back (
   input  logic                 clock,
   input  logic                 reset,
   input  trxon_pkg::cmd_type   cmd_data,
   input  logic                 cmd_empty,
   output logic                 cmd_pop,
   output logic                 rsp_push,
   output trxon_pkg::rsp_type   rsp_data,
   input  logic                 rsp_full
);

   trxon_pkg::phase_type phase_ff, phase_in;
   trxon_pkg::line_type  line_ff, line_in;
   logic                 secret_ff, secret_in;
   logic                 eor_ff, eor_in;
   trxon_pkg::rsp_type   rsp;
   trxon_pkg::cls_type   cls;
   logic [7:0]           value;

   assign cmd_pop  = ~cmd_empty & ~rsp_full;
   assign rsp_push = cmd_pop;
   assign rsp_data = rsp;
   assign cls      = cmd_data.cls;
   assign value    = cmd_data.value;

   always_comb begin
      rsp       = '0;
      phase_in  = phase_ff;
      line_in   = line_ff;
      secret_in = secret_ff;
      eor_in    = eor_ff;
      unique case (phase_ff)
         trxon_pkg::PH_DATA: begin
            line_in = trxon_pkg::LN_NONE;
            if (cls == trxon_pkg::CLS_IAC) begin
               phase_in = trxon_pkg::PH_IAC;
            end else if (cls == trxon_pkg::CLS_CR) begin
               if (line_ff != trxon_pkg::LN_LF) begin
                  rsp.data_valid = 1'b1;
                  rsp.data_byte  = trxon_pkg::B_LF;
                  line_in        = trxon_pkg::LN_CR;
               end
            end else if (cls == trxon_pkg::CLS_LF) begin
               line_in = trxon_pkg::LN_LF;
               if (line_ff != trxon_pkg::LN_CR) begin
                  rsp.data_valid = 1'b1;
                  rsp.data_byte  = trxon_pkg::B_LF;
               end
            end else if (cls != trxon_pkg::CLS_NUL) begin
               rsp.data_valid = 1'b1;
               rsp.data_byte  = value;
            end
         end
         trxon_pkg::PH_IAC: begin
            phase_in = trxon_pkg::PH_DATA;
            unique case (cls)
               trxon_pkg::CLS_IP: begin
                  rsp.close_request = 1'b1;
                  eor_in            = 1'b0;
               end
               trxon_pkg::CLS_GA:   rsp.prompt_mark = ~eor_ff;
               trxon_pkg::CLS_EOR:  rsp.prompt_mark = eor_ff;
               trxon_pkg::CLS_WILL: phase_in = trxon_pkg::PH_WILL;
               trxon_pkg::CLS_WONT: phase_in = trxon_pkg::PH_WONT;
               trxon_pkg::CLS_DO:   phase_in = trxon_pkg::PH_DO;
               trxon_pkg::CLS_DONT: phase_in = trxon_pkg::PH_DONT;
               default: ;
            endcase
         end
         trxon_pkg::PH_WILL: begin
            phase_in = trxon_pkg::PH_DATA;
            if (cls == trxon_pkg::CLS_OPT_ECHO) begin
               if (!secret_ff) begin
                  rsp.reply_valid  = 1'b1;
                  rsp.reply_verb   = trxon_pkg::B_DO;
                  rsp.reply_option = trxon_pkg::OPT_ECHO;
                  secret_in        = 1'b1;
               end
            end else if (cls == trxon_pkg::CLS_OPT_SGA) begin
               rsp.reply_valid  = 1'b1;
               rsp.reply_verb   = trxon_pkg::B_DONT;
               rsp.reply_option = trxon_pkg::OPT_SGA;
            end else if (cls == trxon_pkg::CLS_OPT_EOR) begin
               if (!eor_ff) begin
                  rsp.reply_valid  = 1'b1;
                  rsp.reply_verb   = trxon_pkg::B_DO;
                  rsp.reply_option = trxon_pkg::OPT_EOR;
                  eor_in           = 1'b1;
               end
            end
         end
         trxon_pkg::PH_WONT: begin
            phase_in = trxon_pkg::PH_DATA;
            if (cls == trxon_pkg::CLS_OPT_ECHO) begin
               if (secret_ff) begin
                  rsp.reply_valid  = 1'b1;
                  rsp.reply_verb   = trxon_pkg::B_DONT;
                  rsp.reply_option = trxon_pkg::OPT_ECHO;
                  secret_in        = 1'b0;
               end
            end else if (cls == trxon_pkg::CLS_OPT_EOR) begin
               if (eor_ff) begin
                  rsp.reply_valid  = 1'b1;
                  rsp.reply_verb   = trxon_pkg::B_DONT;
                  rsp.reply_option = trxon_pkg::OPT_EOR;
                  eor_in           = 1'b0;
               end
            end
         end
         trxon_pkg::PH_DO: begin
            phase_in = trxon_pkg::PH_DATA;
            if (cls == trxon_pkg::CLS_OPT_ECHO) begin
               if (secret_ff) begin
                  rsp.reply_valid  = 1'b1;
                  rsp.reply_verb   = trxon_pkg::B_WILL;
                  rsp.reply_option = trxon_pkg::OPT_ECHO;
                  secret_in        = 1'b0;
               end
            end else if (cls == trxon_pkg::CLS_OPT_EOR) begin
               if (!eor_ff) begin
                  rsp.reply_valid  = 1'b1;
                  rsp.reply_verb   = trxon_pkg::B_WILL;
                  rsp.reply_option = trxon_pkg::OPT_EOR;
                  eor_in           = 1'b1;
               end
            end else begin
               rsp.reply_valid  = 1'b1;
               rsp.reply_verb   = trxon_pkg::B_WONT;
               rsp.reply_option = value;
            end
         end
         trxon_pkg::PH_DONT: begin
            phase_in = trxon_pkg::PH_DATA;
            if (cls == trxon_pkg::CLS_OPT_ECHO) begin
               if (!secret_ff) begin
                  rsp.reply_valid  = 1'b1;
                  rsp.reply_verb   = trxon_pkg::B_WONT;
                  rsp.reply_option = trxon_pkg::OPT_ECHO;
                  secret_in        = 1'b1;
               end
            end else if (cls == trxon_pkg::CLS_OPT_EOR) begin
               if (eor_ff) begin
                  rsp.reply_valid  = 1'b1;
                  rsp.reply_verb   = trxon_pkg::B_WONT;
                  rsp.reply_option = trxon_pkg::OPT_EOR;
                  eor_in           = 1'b0;
               end
            end
         end
         default: begin
            phase_in = trxon_pkg::PH_DATA;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= trxon_pkg::PH_DATA;
         line_ff   <= trxon_pkg::LN_NONE;
         secret_ff <= 1'b0;
         eor_ff    <= 1'b0;
      end else if (cmd_pop) begin
         phase_ff  <= phase_in;
         line_ff   <= line_in;
         secret_ff <= secret_in;
         eor_ff    <= eor_in;
      end
   end

endmodule

### rtl/core/trxon_checker.sv
// Port-level checker for the telnet receive option negotiator, with its bind.
`include "assert_macros.svh"

module trxon_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_data_valid,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_prompt_mark,
   input logic       rsp_reply_valid,
   input logic [7:0] rsp_reply_verb,
   input logic [7:0] rsp_reply_option,
   input logic       rsp_close_request
);

   logic kind_ok;
   logic reply_zero_ok;
   logic verb_ok;
   logic data_zero_ok;

   assign kind_ok = ($countones({rsp_data_valid, rsp_prompt_mark,
                                 rsp_reply_valid, rsp_close_request}) <= 1);
   assign reply_zero_ok = (rsp_reply_verb == 8'd0) && (rsp_reply_option == 8'd0);
   assign verb_ok = (rsp_reply_verb == trxon_pkg::B_WILL) ||
                    (rsp_reply_verb == trxon_pkg::B_WONT) ||
                    (rsp_reply_verb == trxon_pkg::B_DO) ||
                    (rsp_reply_verb == trxon_pkg::B_DONT);
   assign data_zero_ok = (rsp_data_byte == 8'd0);

   `ASSERT_NEXT(a_reset_clears, reset, rsp_empty && !req_full, "queues not clear after reset")
   `ASSERT_ALWAYS(a_one_kind, rsp_empty || kind_ok, "more than one result kind")
   `ASSERT_ALWAYS(a_reply_zero, rsp_empty || rsp_reply_valid || reply_zero_ok, "reply fields set")
   `ASSERT_ALWAYS(a_reply_verb, rsp_empty || !rsp_reply_valid || verb_ok, "bad reply verb")
   `ASSERT_ALWAYS(a_data_zero, rsp_empty || rsp_data_valid || data_zero_ok, "data byte set")

endmodule

bind telnet_rx_option_negotiator_unit trxon_checker u_trxon_checker (.*);
